// ----- rtl/smvr_pkg.sv -----
// smvr_pkg: shared types and constants for the mean/variance/rms block
// no dependencies

package smvr_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int CNT_W       = 13;
  localparam int SUM_W       = 29;
  localparam int SQS_W       = 43;
  localparam int Q_DEPTH     = 2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SINGLE = 2'd1;
  localparam logic [1:0] STATUS_EXCESS = 2'd2;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQS_W-1:0]        sumsq;
    logic [CNT_W-1:0]        n;
    logic                    excess;
  } rec_t;

endpackage

// ----- rtl/smvr_front.sv -----
// smvr_front: accumulates count, sum and sum of squares per record
// depends on smvr_pkg

module smvr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc_en,
  input  logic signed [15:0]   sample,
  input  logic                 last_sample,
  output logic                 push,
  output smvr_pkg::rec_t       rec
);
  import smvr_pkg::*;

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQS_W-1:0]        sumsq_r, sumsq_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    exc_r, exc_nxt;
  logic signed [31:0]      prod;
  logic                    room;

  assign prod = sample * sample;
  assign room = cnt_r < CNT_W'(MAX_SAMPLES);

  always_comb begin
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    cnt_nxt   = cnt_r;
    exc_nxt   = exc_r;
    if (room) begin
      sum_nxt   = sum_r + SUM_W'(sample);
      sumsq_nxt = sumsq_r + {{(SQS_W-32){1'b0}}, prod};
      cnt_nxt   = cnt_r + 1'b1;
    end else begin
      exc_nxt = 1'b1;
    end
  end

  assign push       = acc_en & last_sample;
  assign rec.sum    = sum_nxt;
  assign rec.sumsq  = sumsq_nxt;
  assign rec.n      = cnt_nxt;
  assign rec.excess = exc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      sum_r   <= '0;
      sumsq_r <= '0;
      cnt_r   <= '0;
      exc_r   <= 1'b0;
    end else if (acc_en) begin
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      cnt_r   <= cnt_nxt;
      exc_r   <= exc_nxt;
    end
  end

endmodule

// ----- rtl/smvr_queue.sv -----
// smvr_queue: two-entry record queue between accumulator and solver
// depends on smvr_pkg

module smvr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  smvr_pkg::rec_t wr_rec,
  input  logic           pop,
  output smvr_pkg::rec_t rd_rec,
  output logic           not_empty,
  output logic           full
);
  import smvr_pkg::*;

  rec_t       mem_r [Q_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign rd_rec    = mem_r[rp_r];
  assign not_empty = cnt_r != 2'd0;
  assign full      = cnt_r == 2'(Q_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/smvr_back.sv -----
// smvr_back: per-record solver with shared serial divider and square root
// depends on smvr_pkg

module smvr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  smvr_pkg::rec_t       q_rec,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   mean_value,
  output logic [47:0]          variance_value,
  output logic [31:0]          std_deviation,
  output logic [31:0]          rms_value,
  output logic [12:0]          samples_used,
  output logic [1:0]           status
);
  import smvr_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_SUB   = 4'd2;
  localparam logic [3:0] ST_DMEAN = 4'd3;
  localparam logic [3:0] ST_DVAR  = 4'd4;
  localparam logic [3:0] ST_SQSD  = 4'd5;
  localparam logic [3:0] ST_DRMS  = 4'd6;
  localparam logic [3:0] ST_SQRMS = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  localparam int DVD_W = 88;

  logic [3:0]       st_r;
  rec_t             rec_r;
  logic [27:0]      mag;
  logic             neg;
  logic [55:0]      prod_r, sq_r, num_r;
  logic [23:0]      d_r;

  logic [DVD_W-1:0] dvd_r;
  logic [23:0]      dsr_r, rem_r, rem_nxt;
  logic [24:0]      rem_sh;
  logic             dge;
  logic [63:0]      quo_r, quo_nxt;
  logic [6:0]       cnt_r;
  logic             div_done, sq_done;

  logic [63:0]      x_r;
  logic [34:0]      srem_r, srem_sh, trial, srem_nxt;
  logic [31:0]      root_r, root_nxt;
  logic             sge;

  logic signed [31:0] mean_r;
  logic [47:0]        var_r;
  logic [31:0]        sd_r, rms_r;
  logic               ov_r;

  assign neg = rec_r.sum < 0;
  assign mag = neg ? 28'(-rec_r.sum) : 28'(rec_r.sum);

  // restoring divide, one quotient bit a cycle
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign dge      = rem_sh >= {1'b0, dsr_r};
  assign rem_nxt  = dge ? 24'(rem_sh - {1'b0, dsr_r}) : rem_sh[23:0];
  assign quo_nxt  = {quo_r[62:0], dge};
  assign div_done = cnt_r == 7'(DVD_W - 1);

  // square root, one result bit a cycle
  assign srem_sh  = {srem_r[32:0], x_r[63:62]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign sge      = srem_sh >= trial;
  assign srem_nxt = sge ? srem_sh - trial : srem_sh;
  assign root_nxt = {root_r[30:0], sge};
  assign sq_done  = cnt_r == 7'd31;

  assign pop = (st_r == ST_IDLE) && q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            rec_r <= q_rec;
            st_r  <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r <= 56'(rec_r.n) * 56'(rec_r.sumsq);
          sq_r   <= 56'(mag) * 56'(mag);
          d_r    <= 24'(rec_r.n) * 24'(rec_r.n - 13'd1);
          st_r   <= ST_SUB;
        end
        ST_SUB: begin
          num_r <= prod_r - sq_r;
          dvd_r <= {44'd0, mag, 16'd0};
          dsr_r <= {11'd0, rec_r.n};
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= '0;
          st_r  <= ST_DMEAN;
        end
        ST_DMEAN, ST_DVAR, ST_DRMS: begin
          dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 7'd1;
          if (div_done) begin
            cnt_r  <= '0;
            rem_r  <= '0;
            quo_r  <= '0;
            srem_r <= '0;
            root_r <= '0;
            x_r    <= quo_nxt;
            if (st_r == ST_DMEAN) begin
              mean_r <= neg ? 32'd0 - (quo_nxt[31:0] + 32'(rem_nxt != 24'd0))
                            : quo_nxt[31:0];
              if (rec_r.n > 13'd1) begin
                dvd_r <= {num_r, 32'd0};
                dsr_r <= d_r;
                st_r  <= ST_DVAR;
              end else begin
                var_r <= '0;
                sd_r  <= '0;
                dvd_r <= {13'd0, rec_r.sumsq, 32'd0};
                dsr_r <= {11'd0, rec_r.n};
                st_r  <= ST_DRMS;
              end
            end else if (st_r == ST_DVAR) begin
              var_r <= quo_nxt[63:16];
              st_r  <= ST_SQSD;
            end else begin
              st_r <= ST_SQRMS;
            end
          end
        end
        ST_SQSD, ST_SQRMS: begin
          x_r    <= {x_r[61:0], 2'b00};
          srem_r <= srem_nxt;
          root_r <= root_nxt;
          cnt_r  <= cnt_r + 7'd1;
          if (sq_done) begin
            cnt_r <= '0;
            if (st_r == ST_SQSD) begin
              sd_r  <= root_nxt;
              dvd_r <= {13'd0, rec_r.sumsq, 32'd0};
              dsr_r <= {11'd0, rec_r.n};
              rem_r <= '0;
              quo_r <= '0;
              st_r  <= ST_DRMS;
            end else begin
              rms_r <= root_nxt;
              ov_r  <= 1'b1;
              st_r  <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            ov_r <= 1'b0;
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = ov_r;
  assign mean_value     = mean_r;
  assign variance_value = var_r;
  assign std_deviation  = sd_r;
  assign rms_value      = rms_r;
  assign samples_used   = rec_r.n;
  assign status         = rec_r.excess ? STATUS_EXCESS :
                          (rec_r.n == 13'd1) ? STATUS_SINGLE : STATUS_OK;

endmodule

// ----- rtl/signal_mean_variance_rms.sv -----
// signal_mean_variance_rms: top level of the record statistics block
// depends on smvr_pkg, smvr_front, smvr_queue, smvr_back
//
// usage:
//   input channel in_valid/in_stall carries one signed 16-bit sample per
//   transfer, in_last_sample marks the end of a record
//   samples accumulate at one per cycle while in_stall is low; up to 4096 per
//   record are used, later ones are dropped and the record reports status 2
//   at a record end the totals enter a two-entry queue; the solver takes
//   one record at a time, using 88-step serial divides and 32-step square
//   roots; a single-sample record skips the variance divide and its root
//   one result per record on out_valid/out_stall, held until transferred
//   in_stall rises only while the queue is full
//   a stalled output blocks the solver, not the accumulator, until the
//   queue fills
//   synchronous active-low reset clears accumulators, queue and out_valid

module signal_mean_variance_rms (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_sample,
  input  logic                in_last_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_mean_value,
  output logic [47:0]         out_variance_value,
  output logic [31:0]         out_std_deviation,
  output logic [31:0]         out_rms_value,
  output logic [12:0]         out_samples_used,
  output logic [1:0]          out_status
);
  import smvr_pkg::*;

  rec_t f_rec, q_rec;
  logic push, pop, q_ne, q_full, acc_en;

  assign in_stall = q_full;
  assign acc_en   = in_valid & ~q_full;

  smvr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_en      (acc_en),
    .sample      (in_sample),
    .last_sample (in_last_sample),
    .push        (push),
    .rec         (f_rec)
  );

  smvr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_rec    (f_rec),
    .pop       (pop),
    .rd_rec    (q_rec),
    .not_empty (q_ne),
    .full      (q_full)
  );

  smvr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_ne),
    .q_rec          (q_rec),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mean_value     (out_mean_value),
    .variance_value (out_variance_value),
    .std_deviation  (out_std_deviation),
    .rms_value      (out_rms_value),
    .samples_used   (out_samples_used),
    .status         (out_status)
  );

endmodule
